// ----- rtl/core/wzad_pkg.sv -----
package wzad_pkg;

    localparam int unsigned WINDOW_DEF   = 30;
    localparam int unsigned CHANNELS_DEF = 8;

    localparam int unsigned SAMPLE_W = 26;
    localparam int unsigned CH_W     = 3;
    localparam int unsigned CFG_W    = 26;
    localparam int unsigned IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_EWMA_WEIGHT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_SAMPLES  = 2'd1;
    localparam logic [IDX_W-1:0] REG_STDDEV_FLOOR = 2'd2;
    localparam logic [IDX_W-1:0] REG_Z_THRESHOLD  = 2'd3;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Result of one item as it leaves the datapath.
    typedef struct packed {
        logic                anomaly;
        logic                baseline_ready;
        logic [15:0]         z_score;
        logic [SAMPLE_W-1:0] window_mean;
        logic [SAMPLE_W-1:0] window_stddev;
        logic [SAMPLE_W-1:0] smoothed;
    } t_result;

endpackage

// ----- rtl/core/windowed_zscore_anomaly_detector_unit.sv -----
// Per-channel sliding-window z-score detector. Each transfer on the slave side
// carries a channel and a latency sample; one result transfer follows. Items are
// handled one at a time by a sequencer: a multiply step and a combine step for the
// average, a pass over the channel's window to sum, a shared 64-bit restoring
// divider for the mean, a second pass for the squared deviations (one 26x26
// multiply per sample), the divider again for the variance, a bit-pair square
// root (32 steps), and the divider a third time for the z-score. When the stddev
// is zero or below the floor the z-score divide is skipped, and before the
// baseline is ready the result follows the average update directly. The slave
// side is not ready again until the result transfer has completed.
// The sample memory holds undefined data after reset; only written entries are read.
module windowed_zscore_anomaly_detector_unit #(
    parameter int unsigned WINDOW   = wzad_pkg::WINDOW_DEF,
    parameter int unsigned CHANNELS = wzad_pkg::CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // tdata: channel[2:0], sample[28:3], zero pad [31:29]
    input  logic [31:0]                s_axis_tdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: anomaly[0], baseline_ready[1], z_score[17:2], window_mean[43:18],
    // window_stddev[69:44], smoothed[95:70]
    output logic [95:0]                m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic                       i_cfg_we,
    input  logic [wzad_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [wzad_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int unsigned SW    = wzad_pkg::SAMPLE_W;
    localparam int unsigned POS_W = $clog2(WINDOW);
    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam int unsigned CHI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned DEPTH = WINDOW * CHANNELS;
    localparam int unsigned ADR_W = $clog2(DEPTH);
    localparam int unsigned CH_W_T = wzad_pkg::CH_W;

    typedef enum logic [3:0] {
        S_IDLE, S_EWMA1, S_EWMA2, S_SUM, S_MEAN, S_SQ, S_SQACC, S_VAR,
        S_SQRT, S_ZDIV, S_ZWAIT, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [16:0]        r_weight;
    logic [6:0]         r_min;
    logic [SW-1:0]      r_floor;
    logic signed [15:0] r_thr;

    // per-channel state
    logic [POS_W-1:0] r_wpos  [CHANNELS];
    logic [CNT_W-1:0] r_fill  [CHANNELS];
    logic [SW-1:0]    r_avg   [CHANNELS];

    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] r_rd;

    // item registers
    logic [CHI_W-1:0] r_ch;
    logic [ADR_W-1:0] r_base;
    logic [SW-1:0]    r_s;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_i;
    logic             r_rdv;
    logic [63:0]      r_acc;
    logic [SW-1:0]    r_mean;
    logic [53:0]      r_prod;
    logic [63:0]      r_v;
    logic [63:0]      r_root;
    logic [63:0]      r_bit;
    logic [SW-1:0]    r_sd;
    logic             r_neg;
    logic [43:0]      r_p1;
    logic [43:0]      r_p2;
    logic             r_ready;
    wzad_pkg::t_result r_res;
    logic             r_ovalid;

    logic              dv_start;
    logic [63:0]       dv_num;
    logic [31:0]       dv_den;
    logic              dv_done;
    logic [63:0]       dv_quot;

    wzad_divider #(.NUM_W(64), .DEN_W(32)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    logic [CH_W_T-1:0] in_ch;
    logic [SW-1:0]     in_s;
    logic [6:0]        need;
    logic [16:0]       w_sat;
    logic [SW:0]       diff;
    logic [SW-1:0]     absd;
    logic [64:0]       sq_trial;
    logic [63:0]       mag;
    logic signed [15:0] z_sat;

    assign in_ch     = s_axis_tdata[CH_W_T-1:0];
    assign in_s      = s_axis_tdata[CH_W_T +: SW];
    assign need      = (r_min == 7'd0) ? 7'd1 : r_min;
    assign w_sat     = (r_weight > wzad_pkg::ONE_Q16) ? wzad_pkg::ONE_Q16 : r_weight;
    assign diff      = {1'b0, r_rd} - {1'b0, r_mean};
    assign absd      = diff[SW] ? SW'(-diff) : diff[SW-1:0];
    assign sq_trial  = {1'b0, r_v} - {1'b0, r_root + r_bit};
    assign mag       = dv_quot;

    always_comb begin
        if (!r_neg) z_sat = (mag > 64'd32767) ? 16'sd32767 : 16'(mag);
        else        z_sat = (mag >= 64'd32768) ? 16'sh8000 : 16'(-mag);
    end

    always_comb begin
        dv_start = 1'b0;
        dv_num   = r_acc;
        dv_den   = 32'(r_cnt);
        unique case (r_state)
            S_MEAN: dv_start = (r_i == '0) && !r_rdv;
            S_VAR:  dv_start = (r_i == '0) && !r_rdv;
            S_ZDIV: begin
                dv_start = 1'b1;
                dv_num   = {30'd0, (r_neg ? r_mean - r_s : r_s - r_mean), 8'd0};
                dv_den   = 32'(r_sd);
            end
            default: dv_start = 1'b0;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_res.smoothed, r_res.window_stddev, r_res.window_mean,
                            r_res.z_score, r_res.baseline_ready, r_res.anomaly};

    // Sample memory: one write at accept, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready && (32'(in_ch) < CHANNELS))
            mem[ADR_W'(32'(in_ch) * WINDOW + 32'(r_wpos[CHI_W'(in_ch)]))] <= in_s;
        r_rd <= mem[ADR_W'(r_base + ADR_W'(r_i))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_weight <= 17'd13107;
            r_min    <= 7'd5;
            r_floor  <= SW'(1);
            r_thr    <= 16'sd768;
            r_rdv    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wpos[c] <= '0;
                r_fill[c] <= '0;
                r_avg[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wzad_pkg::REG_EWMA_WEIGHT:  r_weight <= i_cfg_data[16:0];
                    wzad_pkg::REG_MIN_SAMPLES:  r_min    <= i_cfg_data[6:0];
                    wzad_pkg::REG_STDDEV_FLOOR: r_floor  <= i_cfg_data[SW-1:0];
                    wzad_pkg::REG_Z_THRESHOLD:  r_thr    <= i_cfg_data[15:0];
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_res <= '0;
                        if (32'(in_ch) >= CHANNELS) begin
                            r_ovalid <= 1'b1;
                        end else begin
                            r_ch   <= CHI_W'(in_ch);
                            r_base <= ADR_W'(32'(in_ch) * WINDOW);
                            r_s    <= in_s;
                            r_wpos[CHI_W'(in_ch)] <=
                                (32'(r_wpos[CHI_W'(in_ch)]) == WINDOW - 1) ? '0
                                : r_wpos[CHI_W'(in_ch)] + 1'b1;
                            if (32'(r_fill[CHI_W'(in_ch)]) < WINDOW) begin
                                r_fill[CHI_W'(in_ch)] <= r_fill[CHI_W'(in_ch)] + 1'b1;
                                r_cnt <= r_fill[CHI_W'(in_ch)] + 1'b1;
                            end else begin
                                r_cnt <= r_fill[CHI_W'(in_ch)];
                            end
                            r_state <= S_EWMA1;
                        end
                    end
                end
                S_EWMA1: begin
                    r_p1    <= 44'(w_sat * r_s);
                    r_p2    <= 44'((wzad_pkg::ONE_Q16 - w_sat) * r_avg[r_ch]);
                    r_state <= S_EWMA2;
                end
                S_EWMA2: begin
                    if (r_cnt == CNT_W'(1)) r_avg[r_ch] <= r_s;
                    else r_avg[r_ch] <= SW'((r_p1 + r_p2 + 44'd32768) >> 16);
                    r_i   <= '0;
                    r_rdv <= 1'b0;
                    r_acc <= '0;
                    if (7'(r_cnt) >= need) begin
                        r_ready <= 1'b1;
                        r_state <= S_SUM;
                    end else begin
                        r_ready <= 1'b0;
                        r_mean  <= '0;
                        r_sd    <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_SUM: begin
                    // Read address leads the accumulate: each read is registered first.
                    r_rdv <= (r_i < r_cnt);
                    if (r_rdv) r_acc <= r_acc + 64'(r_rd);
                    if (r_i < r_cnt) r_i <= r_i + 1'b1;
                    else if (!r_rdv) begin
                        r_i     <= '0;
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (dv_done) begin
                        r_mean  <= SW'(dv_quot);
                        r_acc   <= '0;
                        r_rdv   <= 1'b0;
                        r_state <= S_SQ;
                    end else begin
                        r_rdv   <= 1'b1;
                    end
                end
                S_SQ: begin
                    // Each sample takes a read, a multiply and an accumulate step, in that order.
                    if (r_rdv) begin
                        r_prod  <= 54'(absd * absd);
                        r_rdv   <= 1'b0;
                        r_state <= S_SQACC;
                    end else if (r_i < r_cnt) begin
                        r_rdv <= 1'b1;
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_VAR;
                    end
                end
                S_SQACC: begin
                    r_acc   <= r_acc + 64'(r_prod);
                    r_state <= S_SQ;
                end
                S_VAR: begin
                    r_rdv <= 1'b1;
                    if (dv_done) begin
                        r_v     <= dv_quot;
                        r_root  <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_sd    <= SW'(r_root);
                        r_neg   <= r_s < r_mean;
                        r_state <= ((r_root != '0) && (SW'(r_root) >= r_floor))
                                   ? S_ZDIV : S_OUT;
                    end else begin
                        if (!sq_trial[64]) begin
                            r_v    <= sq_trial[63:0];
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_ZDIV:  r_state <= S_ZWAIT;
                S_ZWAIT: begin
                    if (dv_done) begin
                        r_res.z_score <= z_sat;
                        r_res.anomaly <= z_sat > r_thr;
                        r_state       <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_res.baseline_ready <= r_ready;
                    r_res.window_mean    <= r_mean;
                    r_res.window_stddev  <= r_sd;
                    r_res.smoothed       <= r_avg[r_ch];
                    r_ovalid             <= 1'b1;
                    r_rdv                <= 1'b0;
                    r_state              <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_anom_ready;
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]);
    endproperty
    a_anom_ready: assert property (p_anom_ready) else $error("anomaly without baseline");

    property p_sd_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[69:44] == '0) |-> (m_axis_tdata[17:2] == '0);
    endproperty
    a_sd_zero: assert property (p_sd_zero) else $error("z-score with zero stddev");
endmodule

// ----- rtl/core/wzad_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module wzad_divider #(
    parameter int unsigned NUM_W = 64,
    parameter int unsigned DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] shifted;

    always_comb begin
        shifted = {r_rem, r_quot[NUM_W-1]};
        trial   = shifted[DEN_W:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                if (shifted >= {1'b0, 1'b0, r_den}) begin
                    r_rem  <= (DEN_W+1)'(shifted - {2'b0, r_den});
                    r_quot <= {r_quot[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem  <= trial;
                    r_quot <= {r_quot[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- dv/windowed_zscore_anomaly_detector_unit_test.sv -----
`timescale 1ns / 100ps

module windowed_zscore_anomaly_detector_unit_test;

    localparam int unsigned NCH       = 8;
    localparam int unsigned WIN       = 30;
    localparam int unsigned STALL_MAX = 20000;
    localparam logic [25:0] SMAX      = 26'h3FFFFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [wzad_pkg::IDX_W-1:0] i_cfg_index = '0;
    logic [wzad_pkg::CFG_W-1:0] i_cfg_data = '0;

    windowed_zscore_anomaly_detector_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow of the detector state and registers.
    logic [25:0] win_store [NCH][WIN];
    int unsigned win_pos [NCH];
    int unsigned win_fill [NCH];
    logic [25:0] ch_avg [NCH];
    logic [16:0] cfg_weight;
    logic [6:0]  cfg_min;
    logic [25:0] cfg_floor;
    logic [15:0] cfg_thr;

    wzad_pkg::t_result score_q[$];
    int unsigned mismatches = 0;
    int unsigned send_pct = 0;
    int unsigned recv_pct = 0;
    int unsigned quiet_cycles = 0;

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic wzad_pkg::t_result score_sample(input logic [2:0] ch,
                                                       input logic [25:0] smp);
        wzad_pkg::t_result r;
        longint unsigned wgt, acc, sum, sq, d, mag;
        longint unsigned mean, sd;
        int unsigned cnt, need;
        int z;
        r = '0;
        win_store[ch][win_pos[ch]] = smp;
        win_pos[ch] = (win_pos[ch] + 1) % WIN;
        if (win_fill[ch] < WIN) win_fill[ch]++;
        cnt = win_fill[ch];
        wgt = (cfg_weight > 17'd65536) ? 65536 : cfg_weight;
        if (cnt == 1) begin
            ch_avg[ch] = smp;
        end else begin
            acc = wgt * smp + (65536 - wgt) * ch_avg[ch] + 32768;
            ch_avg[ch] = acc[41:16];
        end
        need = (cfg_min == 0) ? 1 : cfg_min;
        z = 0;
        if (cnt >= need) begin
            r.baseline_ready = 1'b1;
            sum = 0;
            sq = 0;
            for (int i = 0; i < cnt; i++) sum += win_store[ch][i];
            mean = sum / cnt;
            for (int i = 0; i < cnt; i++) begin
                d = (win_store[ch][i] >= mean) ? win_store[ch][i] - mean
                                               : mean - win_store[ch][i];
                sq += d * d;
            end
            sd = isqrt(sq / cnt);
            r.window_mean = mean[25:0];
            r.window_stddev = sd[25:0];
            if (sd != 0 && sd >= cfg_floor) begin
                if (smp >= mean) begin
                    mag = ((smp - mean) << 8) / sd;
                    z = (mag > 32767) ? 32767 : int'(mag);
                end else begin
                    mag = ((mean - smp) << 8) / sd;
                    z = (mag >= 32768) ? -32768 : -int'(mag);
                end
                r.anomaly = (z > int'($signed(cfg_thr)));
            end
        end
        r.z_score = z[15:0];
        r.smoothed = ch_avg[ch];
        return r;
    endfunction

    task automatic write_reg(input logic [wzad_pkg::IDX_W-1:0] idx,
                             input logic [25:0] val);
        // Only touch registers with the pipeline drained.
        while (score_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            wzad_pkg::REG_EWMA_WEIGHT:  cfg_weight = val[16:0];
            wzad_pkg::REG_MIN_SAMPLES:  cfg_min = val[6:0];
            wzad_pkg::REG_STDDEV_FLOOR: cfg_floor = val;
            wzad_pkg::REG_Z_THRESHOLD:  cfg_thr = val[15:0];
            default: ;
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_sample(input logic [2:0] ch, input logic [25:0] smp,
                               input bit typed, input wzad_pkg::t_result fixed);
        bit fire;
        wzad_pkg::t_result r;
        if (send_pct != 0 && $urandom_range(99) < send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, smp, ch};
        do begin
            @(negedge i_clk);
            fire = s_axis_tvalid && s_axis_tready;
            @(posedge i_clk);
        end while (!fire);
        r = score_sample(ch, smp);
        score_q.push_back(typed ? fixed : r);
    endtask

    task automatic check_result(input logic [95:0] data);
        wzad_pkg::t_result got, want;
        got.anomaly = data[0];
        got.baseline_ready = data[1];
        got.z_score = data[17:2];
        got.window_mean = data[43:18];
        got.window_stddev = data[69:44];
        got.smoothed = data[95:70];
        if (score_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", data);
            return;
        end
        want = score_q.pop_front();
        if (got.anomaly !== want.anomaly || got.baseline_ready !== want.baseline_ready ||
            got.z_score !== want.z_score || got.window_mean !== want.window_mean ||
            got.window_stddev !== want.window_stddev || got.smoothed !== want.smoothed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: anom %b/%b rdy %b/%b z %h/%h mean %h/%h sd %h/%h avg %h/%h",
                         want.anomaly, got.anomaly, want.baseline_ready, got.baseline_ready,
                         want.z_score, got.z_score, want.window_mean, got.window_mean,
                         want.window_stddev, got.window_stddev, want.smoothed, got.smoothed);
        end
    endtask

    // Result side: check at the falling edge, drive ready at the rising edge.
    initial begin
        forever begin
            @(negedge i_clk);
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("windowed_zscore_anomaly_detector_unit_test failed");
                $finish;
            end
            @(posedge i_clk);
            m_axis_tready <= !(recv_pct != 0 && $urandom_range(99) < recv_pct);
        end
    end

    function automatic logic [25:0] pick_weight();
        case ($urandom_range(5))
            0: return 26'd0;
            1: return 26'd65536;
            2: return 26'h1FFFF;
            default: return 26'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [25:0] pick_min();
        case ($urandom_range(9))
            0: return 26'd0;
            1: return 26'd30;
            2: return 26'd31;
            3: return 26'd127;
            4: return 26'd1;
            default: return 26'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [25:0] pick_floor();
        case ($urandom_range(7))
            0: return 26'd0;
            1: return SMAX;
            2: return 26'd1;
            default: return 26'($urandom_range(200));
        endcase
    endfunction

    function automatic logic [25:0] pick_thr();
        case ($urandom_range(6))
            0: return 26'h0008000;
            1: return 26'h0007FFF;
            2: return 26'd0;
            3: return 26'd768;
            default: return {10'd0, 16'($urandom)};
        endcase
    endfunction

    typedef struct {
        bit                is_cfg;
        logic [1:0]        idx;
        logic [25:0]       val;
        logic [2:0]        ch;
        bit                typed;
        wzad_pkg::t_result res;
    } t_row;

    t_row plan[$];

    function automatic void add_item(input logic [2:0] ch, input logic [25:0] smp);
        plan.push_back('{1'b0, 2'd0, smp, ch, 1'b0, '0});
    endfunction

    function automatic void add_fixed(input logic [2:0] ch, input logic [25:0] smp,
                                      input wzad_pkg::t_result r);
        plan.push_back('{1'b0, 2'd0, smp, ch, 1'b1, r});
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [25:0] val);
        plan.push_back('{1'b1, idx, val, 3'd0, 1'b0, '0});
    endfunction

    logic [25:0] ch_base [NCH];

    initial begin
        logic [2:0]  ch;
        logic [25:0] smp;
        int unsigned mode;
        for (int c = 0; c < NCH; c++) begin
            win_pos[c] = 0;
            win_fill[c] = 0;
            ch_avg[c] = '0;
        end
        cfg_weight = 17'd13107;
        cfg_min = 7'd5;
        cfg_floor = 26'd1;
        cfg_thr = 16'd768;

        // First sample seeds the average; nothing else is ready yet.
        add_fixed(3'd0, 26'd1000, '{1'b0, 1'b0, 16'd0, 26'd0, 26'd0, 26'd1000});
        add_item(3'd0, 26'd0);
        add_item(3'd0, SMAX);
        add_item(3'd0, 26'd1000);
        add_item(3'd0, 26'd1000);
        add_item(3'd0, SMAX);
        add_item(3'd0, 26'd0);
        // A minimum of zero acts as one; a single sample has zero spread.
        add_cfg(wzad_pkg::REG_MIN_SAMPLES, 26'd0);
        add_fixed(3'd1, 26'd5, '{1'b0, 1'b1, 16'd0, 26'd5, 26'd0, 26'd5});
        add_fixed(3'd1, 26'd5, '{1'b0, 1'b1, 16'd0, 26'd5, 26'd0, 26'd5});
        add_cfg(wzad_pkg::REG_STDDEV_FLOOR, 26'd0);
        add_item(3'd1, 26'd7);
        add_item(3'd1, 26'd2000);
        add_cfg(wzad_pkg::REG_EWMA_WEIGHT, 26'h1FFFF);
        add_item(3'd7, 26'd300);
        add_item(3'd7, 26'd900);
        add_cfg(wzad_pkg::REG_EWMA_WEIGHT, 26'd0);
        add_item(3'd7, 26'd5000);
        add_cfg(wzad_pkg::REG_Z_THRESHOLD, 26'h0008000);
        add_item(3'd1, 26'd6);
        add_cfg(wzad_pkg::REG_Z_THRESHOLD, 26'h0007FFF);
        add_item(3'd1, SMAX);
        add_cfg(wzad_pkg::REG_STDDEV_FLOOR, SMAX);
        add_item(3'd1, 26'd3);
        add_cfg(wzad_pkg::REG_MIN_SAMPLES, 26'd127);
        add_item(3'd0, 26'd1234);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                write_reg(plan[k].idx, plan[k].val);
            end else begin
                send_sample(plan[k].ch, plan[k].val, plan[k].typed, plan[k].res);
            end
        end

        for (int c = 0; c < NCH; c++) ch_base[c] = 26'($urandom_range(50, 100000));

        for (int ph = 0; ph < 13; ph++) begin
            mode = (ph < 5) ? 0 : (ph < 9) ? 1 : 2;
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            write_reg(wzad_pkg::REG_EWMA_WEIGHT, (ph == 0) ? 26'h1FFFF : pick_weight());
            write_reg(wzad_pkg::REG_MIN_SAMPLES, (ph == 1) ? 26'd30 : pick_min());
            write_reg(wzad_pkg::REG_STDDEV_FLOOR, (ph == 2) ? SMAX : pick_floor());
            write_reg(wzad_pkg::REG_Z_THRESHOLD, (ph == 3) ? 26'h0008000 : pick_thr());
            send_pct = (mode == 0) ? 37 : (mode == 1) ? 81 : 0;
            recv_pct = (mode == 0) ? 81 : (mode == 1) ? 37 : 0;
            for (int n = 0; n < 150; n++) begin
                ch = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(2));
                case ($urandom_range(19))
                    0: smp = 26'($urandom);
                    1: smp = SMAX;
                    2: smp = 26'd0;
                    3, 4: smp = 26'(ch_base[ch]
                                    + $urandom_range(20 * (ch_base[ch] / 8 + 10)));
                    default: smp = 26'(ch_base[ch] + $urandom_range(ch_base[ch] / 8 + 10)
                                       - ch_base[ch] / 16);
                endcase
                send_sample(ch, smp, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (score_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && score_q.size() == 0) begin
            $display("windowed_zscore_anomaly_detector_unit_test passed");
        end else begin
            $display("windowed_zscore_anomaly_detector_unit_test failed");
        end
        $finish;
    end

endmodule
